// File: hdl/mbg_pkg.sv
// shared widths, defaults, op codes and controller/datapath interface types
// for the metronome beat generator; no dependencies
package mbg_pkg;

    // fixed field widths
    localparam int OP_W        = 3;
    localparam int DELTA_W     = 5;
    localparam int INTERVAL_W  = 16;
    localparam int ELAPSED_W   = 16;
    localparam int CFG_BPM_W   = 9;
    localparam int CFG_MEAS_W  = 6;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_DATA_W   = 8;

    // parameter defaults
    localparam int DEF_MAX_TEMPO        = 500;
    localparam int DEF_MAX_MEASURE      = 32;
    localparam int DEF_TICKS_PER_MINUTE = 60000;

    // reset settings
    localparam int RESET_TEMPO   = 80;
    localparam int RESET_MEASURE = 4;

    // input op codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK        = 3'd0,
        OP_TOGGLE      = 3'd1,
        OP_ADJ_TEMPO   = 3'd2,
        OP_ADJ_MEASURE = 3'd3,
        OP_LOAD        = 3'd4,
        OP_STOP        = 3'd5
    } op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_BPM     = 1'b0,
        REG_START_MEASURE = 1'b1
    } cfg_idx_t;

    // controller to datapath commands
    typedef struct packed {
        logic apply;      // update state from the accepted item
        logic div_start;  // start the interval division
        logic load_now;   // capture result from this item's state update
        logic load_div;   // capture result with the new quotient
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_busy;
        logic div_done;
    } dp_status_t;

endpackage

// File: hdl/mbg_ctrl.sv
// controller state machine: input/output handshake and divider sequencing
// depends on mbg_pkg
module mbg_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  mbg_pkg::op_t           op,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output mbg_pkg::dp_cmd_t       cmd,
    input  mbg_pkg::dp_status_t    st
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_DIVIDE = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;
    logic   accept;
    logic   needs_div;

    // handshake and decode
    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;
    assign needs_div = (op == mbg_pkg::OP_ADJ_TEMPO) || (op == mbg_pkg::OP_LOAD);
    assign m_tvalid  = out_valid_reg;

    // commands
    always_comb
    begin
        cmd.apply     = accept;
        cmd.div_start = accept && needs_div;
        cmd.load_now  = accept && !needs_div;
        cmd.load_div  = (state_reg == ST_DIVIDE) && st.div_done;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.div_start)
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (st.div_done)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // output slot occupancy
    always_comb
    begin
        if (cmd.load_now || cmd.load_div)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_div_enters: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (state_reg == ST_DIVIDE) && st.div_busy)
        else $error("division did not start after tempo item");

    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_div |-> slot_free)
        else $error("quotient result overwrites a pending item");

    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_now && cmd.load_div))
        else $error("two result loads in one cycle");
`endif

endmodule

// File: hdl/mbg_datapath.sv
// datapath: settings, metronome state, bit-serial interval divider and
// result register; depends on mbg_pkg
module mbg_datapath #(
    parameter int MAX_TEMPO        = mbg_pkg::DEF_MAX_TEMPO,
    parameter int MAX_MEASURE      = mbg_pkg::DEF_MAX_MEASURE,
    parameter int TICKS_PER_MINUTE = mbg_pkg::DEF_TICKS_PER_MINUTE,
    parameter int TEMPO_W          = $clog2(MAX_TEMPO + 1),
    parameter int MEAS_W           = $clog2(MAX_MEASURE + 1),
    parameter int OUT_DATA_W       = ((3 + TEMPO_W + MEAS_W + mbg_pkg::INTERVAL_W + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mbg_pkg::dp_cmd_t                    cmd,
    output mbg_pkg::dp_status_t                 st,
    input  mbg_pkg::op_t                        op,
    input  logic signed [mbg_pkg::DELTA_W-1:0]  delta,
    input  logic                                cfg_we,
    input  logic [mbg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mbg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output logic [OUT_DATA_W-1:0]               m_tdata
);

    localparam int DW      = mbg_pkg::DELTA_W;
    localparam int IW      = mbg_pkg::INTERVAL_W;
    localparam int EW      = mbg_pkg::ELAPSED_W;
    localparam int SUM_T_W = TEMPO_W + DW;
    localparam int SUM_M_W = MEAS_W + DW;
    localparam int LD_T_W  = (TEMPO_W > mbg_pkg::CFG_BPM_W) ? TEMPO_W : mbg_pkg::CFG_BPM_W;
    localparam int LD_M_W  = (MEAS_W > mbg_pkg::CFG_MEAS_W) ? MEAS_W : mbg_pkg::CFG_MEAS_W;
    localparam int DIV_W   = $clog2(TICKS_PER_MINUTE + 1);
    localparam int CNT_W   = $clog2(DIV_W + 1);
    localparam int PAY_W   = 3 + TEMPO_W + MEAS_W + IW;
    localparam int RST_T   = (mbg_pkg::RESET_TEMPO < MAX_TEMPO) ?
                             mbg_pkg::RESET_TEMPO : MAX_TEMPO;
    localparam int RST_M   = (mbg_pkg::RESET_MEASURE < MAX_MEASURE) ?
                             mbg_pkg::RESET_MEASURE : MAX_MEASURE;
    localparam int RST_I   = TICKS_PER_MINUTE / RST_T;

    localparam logic signed [SUM_T_W-1:0] T_LO = SUM_T_W'(1);
    localparam logic signed [SUM_T_W-1:0] T_HI = SUM_T_W'(MAX_TEMPO);
    localparam logic signed [SUM_M_W-1:0] M_LO = SUM_M_W'(0);
    localparam logic signed [SUM_M_W-1:0] M_HI = SUM_M_W'(MAX_MEASURE);
    localparam logic [EW-1:0]             ELAPSED_MAX = {EW{1'b1}};

    // settings registers
    logic [mbg_pkg::CFG_BPM_W-1:0]  start_bpm_reg;
    logic [mbg_pkg::CFG_MEAS_W-1:0] start_measure_reg;

    // metronome state
    logic [TEMPO_W-1:0] tempo_reg,    tempo_next;
    logic [MEAS_W-1:0]  measure_reg,  measure_next;
    logic [MEAS_W-1:0]  position_reg, position_next;
    logic               run_reg,      run_next;
    logic [EW-1:0]      elapsed_reg,  elapsed_next;
    logic [IW-1:0]      interval_reg;
    logic               beat_next;
    logic               accent_next;

    // divider
    logic               div_busy_reg;
    logic [CNT_W-1:0]   div_cnt_reg;
    logic [TEMPO_W-1:0] div_rem_reg;
    logic [DIV_W-1:0]   div_work_reg;
    logic [TEMPO_W:0]   div_trial;
    logic               div_bit;

    // result register
    logic               out_beat_reg;
    logic               out_accent_reg;
    logic               out_run_reg;
    logic [TEMPO_W-1:0] out_tempo_reg;
    logic [MEAS_W-1:0]  out_measure_reg;
    logic [IW-1:0]      out_interval_reg;

    // saturation helpers
    logic signed [SUM_T_W-1:0] t_sum;
    logic signed [SUM_M_W-1:0] m_sum;
    logic [TEMPO_W-1:0]        t_adj;
    logic [MEAS_W-1:0]         m_adj;
    logic [LD_T_W-1:0]         ld_bpm;
    logic [LD_M_W-1:0]         ld_meas;
    logic [TEMPO_W-1:0]        t_load;
    logic [MEAS_W-1:0]         m_load;
    logic [MEAS_W-1:0]         pos_inc;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_bpm_reg     <= mbg_pkg::CFG_BPM_W'(mbg_pkg::RESET_TEMPO);
            start_measure_reg <= mbg_pkg::CFG_MEAS_W'(mbg_pkg::RESET_MEASURE);
        end
        else if (cfg_we)
        begin
            unique case (mbg_pkg::cfg_idx_t'(cfg_index))
                mbg_pkg::REG_START_BPM:
                    start_bpm_reg <= cfg_wdata[mbg_pkg::CFG_BPM_W-1:0];
                mbg_pkg::REG_START_MEASURE:
                    start_measure_reg <= cfg_wdata[mbg_pkg::CFG_MEAS_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // saturated adjust and load values
    always_comb
    begin
        t_sum = $signed({{DW{1'b0}}, tempo_reg}) + SUM_T_W'(delta);
        m_sum = $signed({{DW{1'b0}}, measure_reg}) + SUM_M_W'(delta);

        if (t_sum < T_LO)
            t_adj = TEMPO_W'(1);
        else if (t_sum > T_HI)
            t_adj = TEMPO_W'(MAX_TEMPO);
        else
            t_adj = t_sum[TEMPO_W-1:0];

        if (m_sum < M_LO)
            m_adj = '0;
        else if (m_sum > M_HI)
            m_adj = MEAS_W'(MAX_MEASURE);
        else
            m_adj = m_sum[MEAS_W-1:0];

        ld_bpm  = LD_T_W'(start_bpm_reg);
        ld_meas = LD_M_W'(start_measure_reg);

        if (ld_bpm == '0)
            t_load = TEMPO_W'(1);
        else if (ld_bpm > LD_T_W'(MAX_TEMPO))
            t_load = TEMPO_W'(MAX_TEMPO);
        else
            t_load = ld_bpm[TEMPO_W-1:0];

        if (ld_meas > LD_M_W'(MAX_MEASURE))
            m_load = MEAS_W'(MAX_MEASURE);
        else
            m_load = ld_meas[MEAS_W-1:0];
    end

    // state update for one item
    always_comb
    begin
        tempo_next    = tempo_reg;
        measure_next  = measure_reg;
        position_next = position_reg;
        run_next      = run_reg;
        elapsed_next  = elapsed_reg;
        beat_next     = 1'b0;
        accent_next   = 1'b0;
        pos_inc       = position_reg + MEAS_W'(1);
        case (op)
            mbg_pkg::OP_TICK:
            begin
                if (run_reg)
                begin
                    if (elapsed_reg >= interval_reg)
                    begin
                        beat_next     = 1'b1;
                        accent_next   = (position_reg == '0) && (measure_reg != '0);
                        position_next = (pos_inc >= measure_reg) ? '0 : pos_inc;
                        elapsed_next  = EW'(1);
                    end
                    else if (elapsed_reg != ELAPSED_MAX)
                        elapsed_next = elapsed_reg + EW'(1);
                end
            end
            mbg_pkg::OP_TOGGLE:
            begin
                if (run_reg)
                begin
                    run_next     = 1'b0;
                    elapsed_next = '0;
                end
                else
                begin
                    run_next      = 1'b1;
                    position_next = '0;
                    elapsed_next  = ELAPSED_MAX;
                end
            end
            mbg_pkg::OP_ADJ_TEMPO:
                tempo_next = t_adj;
            mbg_pkg::OP_ADJ_MEASURE:
                measure_next = m_adj;
            mbg_pkg::OP_LOAD:
            begin
                tempo_next   = t_load;
                measure_next = m_load;
            end
            mbg_pkg::OP_STOP:
            begin
                run_next     = 1'b0;
                elapsed_next = '0;
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_reg    <= TEMPO_W'(RST_T);
            measure_reg  <= MEAS_W'(RST_M);
            position_reg <= '0;
            run_reg      <= 1'b0;
            elapsed_reg  <= '0;
        end
        else if (cmd.apply)
        begin
            tempo_reg    <= tempo_next;
            measure_reg  <= measure_next;
            position_reg <= position_next;
            run_reg      <= run_next;
            elapsed_reg  <= elapsed_next;
        end
    end

    // restoring divider, one quotient bit per cycle: ticks per minute / tempo
    assign div_trial   = {div_rem_reg, div_work_reg[DIV_W-1]};
    assign div_bit     = (div_trial >= {1'b0, tempo_reg});
    assign st.div_busy = div_busy_reg;
    assign st.div_done = div_busy_reg && (div_cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
            interval_reg <= IW'(RST_I);
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= CNT_W'(DIV_W);
        end
        else if (st.div_done)
        begin
            div_busy_reg <= 1'b0;
            interval_reg <= IW'(div_work_reg);
        end
        else if (div_busy_reg)
            div_cnt_reg <= div_cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_rem_reg  <= '0;
            div_work_reg <= DIV_W'(TICKS_PER_MINUTE);
        end
        else if (div_busy_reg && (div_cnt_reg != '0))
        begin
            div_rem_reg  <= div_bit ? TEMPO_W'(div_trial - {1'b0, tempo_reg})
                                    : div_trial[TEMPO_W-1:0];
            div_work_reg <= {div_work_reg[DIV_W-2:0], div_bit};
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_now)
        begin
            out_beat_reg     <= beat_next;
            out_accent_reg   <= accent_next;
            out_run_reg      <= run_next;
            out_tempo_reg    <= tempo_next;
            out_measure_reg  <= measure_next;
            out_interval_reg <= interval_reg;
        end
        else if (cmd.load_div)
        begin
            out_beat_reg     <= 1'b0;
            out_accent_reg   <= 1'b0;
            out_run_reg      <= run_reg;
            out_tempo_reg    <= tempo_reg;
            out_measure_reg  <= measure_reg;
            out_interval_reg <= IW'(div_work_reg);
        end
    end

    assign m_tdata = {{(OUT_DATA_W - PAY_W){1'b0}}, out_interval_reg, out_measure_reg,
                      out_tempo_reg, out_run_reg, out_accent_reg, out_beat_reg};

`ifndef SYNTHESIS
    a_tempo_range: assert property (@(posedge clk) disable iff (!rst_n)
        (tempo_reg != '0) && (tempo_reg <= TEMPO_W'(MAX_TEMPO)))
        else $error("tempo out of range");

    a_no_apply_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy_reg |-> !cmd.apply)
        else $error("item accepted while interval division runs");
`endif

endmodule

// File: hdl/metronome_beat_generator.sv
// Metronome beat generator top level: streaming item ports, settings port.
// Result: registered in the cycle after accept for ticks, toggle, stop and measure items;
// tempo adjust and load items run the divider, then the result takes the new quotient.
// Throughput: one item per cycle while the output is not stalled; no new item is taken
// while the bit-serial divider recomputes the interval one quotient bit per cycle.
// Reset (async, active low): stopped, tempo 80, measure 4, interval 750, no result held.
module metronome_beat_generator #(
    parameter int MAX_TEMPO        = mbg_pkg::DEF_MAX_TEMPO,
    parameter int MAX_MEASURE      = mbg_pkg::DEF_MAX_MEASURE,
    parameter int TICKS_PER_MINUTE = mbg_pkg::DEF_TICKS_PER_MINUTE,
    parameter int TEMPO_W          = $clog2(MAX_TEMPO + 1),
    parameter int MEAS_W           = $clog2(MAX_MEASURE + 1),
    parameter int OUT_DATA_W       = ((3 + TEMPO_W + MEAS_W + mbg_pkg::INTERVAL_W + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mbg_pkg::IN_DATA_W-1:0]      s_tdata,   // op, delta
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [OUT_DATA_W-1:0]              m_tdata,   // beat, accent, running, tempo,
                                                          // measure, interval_ms, zero pad
    input  logic                               cfg_we,
    input  logic [mbg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mbg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    mbg_pkg::dp_cmd_t                   cmd;
    mbg_pkg::dp_status_t                st;
    mbg_pkg::op_t                       op;
    logic signed [mbg_pkg::DELTA_W-1:0] delta;

    // unpack input item
    assign op    = mbg_pkg::op_t'(s_tdata[mbg_pkg::OP_W-1:0]);
    assign delta = $signed(s_tdata[mbg_pkg::OP_W +: mbg_pkg::DELTA_W]);

    mbg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .st       (st)
    );

    mbg_datapath #(
        .MAX_TEMPO        (MAX_TEMPO),
        .MAX_MEASURE      (MAX_MEASURE),
        .TICKS_PER_MINUTE (TICKS_PER_MINUTE),
        .TEMPO_W          (TEMPO_W),
        .MEAS_W           (MEAS_W),
        .OUT_DATA_W       (OUT_DATA_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .op        (op),
        .delta     (delta),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata)
    );

endmodule

// File: tb/mbg_checker.sv
// item checker for the metronome beat generator: follows the input, output and settings
// channels, keeps its own metronome state and compares every result item; uses mbg_pkg
`timescale 1ns / 100ps

module mbg_checker #(
    parameter int M_DATA_W = 40
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [mbg_pkg::IN_DATA_W-1:0]    s_tdata,    // op, delta
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [M_DATA_W-1:0]              m_tdata,    // beat, accent, running, tempo,
                                                         // measure, interval_ms, zero pad
    input  logic                             cfg_we,
    input  logic [mbg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mbg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output int                               pending,
    output int                               mismatches,
    output int                               beats_seen
);

    localparam int TEMPO_W  = 9;
    localparam int MEAS_W   = 6;
    localparam int POS_W    = 5;
    localparam int IW       = mbg_pkg::INTERVAL_W;
    localparam int EW       = mbg_pkg::ELAPSED_W;
    localparam int STATUS_W = 3 + TEMPO_W + MEAS_W + IW;

    // one result item, beat in the lowest bit as on m_tdata
    typedef struct packed {
        logic [IW-1:0]         interval_ms;
        logic [MEAS_W-1:0]     measure;
        logic [TEMPO_W-1:0]    tempo;
        logic                  running;
        logic                  accent;
        logic                  beat;
    } beat_status_t;

    // settings registers and metronome state as the checker sees them
    logic [mbg_pkg::CFG_BPM_W-1:0]  start_bpm;
    logic [mbg_pkg::CFG_MEAS_W-1:0] start_meas;
    logic [TEMPO_W-1:0]             tempo;
    logic [MEAS_W-1:0]              measure_len;
    logic [POS_W-1:0]               position;
    logic                           run_on;
    logic [EW-1:0]                  elapsed;
    logic [IW-1:0]                  interval;

    beat_status_t status_q[$];
    int           result_no;

    function automatic int clamp(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // apply one item to the metronome state, return the status it reports
    function automatic beat_status_t advance_metronome(
        input logic [mbg_pkg::OP_W-1:0]    op,
        input logic [mbg_pkg::DELTA_W-1:0] delta_bits);
        beat_status_t r;
        int           step;
        int           next_pos;
        r    = '0;
        step = $signed(delta_bits);
        case (op)
            mbg_pkg::OP_TICK:
            begin
                if (run_on)
                begin
                    if (elapsed >= interval)
                    begin
                        r.beat   = 1'b1;
                        r.accent = (position == 0) && (measure_len != 0);
                        next_pos = int'(position) + 1;
                        position = (next_pos >= int'(measure_len)) ? '0 : POS_W'(next_pos);
                        elapsed  = EW'(1);
                    end
                    else if (elapsed != '1)
                    begin
                        elapsed = elapsed + 1'b1;
                    end
                end
            end
            mbg_pkg::OP_TOGGLE:
            begin
                if (run_on)
                begin
                    run_on  = 1'b0;
                    elapsed = '0;
                end
                else
                begin
                    run_on   = 1'b1;
                    position = '0;
                    elapsed  = '1;
                end
            end
            mbg_pkg::OP_ADJ_TEMPO:
            begin
                tempo    = TEMPO_W'(clamp(int'(tempo) + step, 1, mbg_pkg::DEF_MAX_TEMPO));
                interval = IW'(mbg_pkg::DEF_TICKS_PER_MINUTE / int'(tempo));
            end
            mbg_pkg::OP_ADJ_MEASURE:
            begin
                measure_len = MEAS_W'(clamp(int'(measure_len) + step, 0,
                                            mbg_pkg::DEF_MAX_MEASURE));
            end
            mbg_pkg::OP_LOAD:
            begin
                tempo       = TEMPO_W'(clamp(int'(start_bpm), 1, mbg_pkg::DEF_MAX_TEMPO));
                measure_len = MEAS_W'(clamp(int'(start_meas), 0, mbg_pkg::DEF_MAX_MEASURE));
                interval    = IW'(mbg_pkg::DEF_TICKS_PER_MINUTE / int'(tempo));
            end
            mbg_pkg::OP_STOP:
            begin
                run_on  = 1'b0;
                elapsed = '0;
            end
            default:
            begin
                // spare codes leave the state alone
            end
        endcase
        r.running     = run_on;
        r.tempo       = tempo;
        r.measure     = measure_len;
        r.interval_ms = interval;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      result_no, name, got, want));
    endtask

    // follow settings writes, accepted items and accepted results
    always @(posedge clk or negedge rst_n)
    begin
        beat_status_t got;
        beat_status_t want;
        if (!rst_n)
        begin
            start_bpm   = mbg_pkg::CFG_BPM_W'(mbg_pkg::RESET_TEMPO);
            start_meas  = mbg_pkg::CFG_MEAS_W'(mbg_pkg::RESET_MEASURE);
            tempo       = TEMPO_W'(mbg_pkg::RESET_TEMPO);
            measure_len = MEAS_W'(mbg_pkg::RESET_MEASURE);
            position    = '0;
            run_on      = 1'b0;
            elapsed     = '0;
            interval    = IW'(mbg_pkg::DEF_TICKS_PER_MINUTE / mbg_pkg::RESET_TEMPO);
            status_q.delete();
            result_no   = 0;
            mismatches  = 0;
            beats_seen  = 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    mbg_pkg::REG_START_BPM:
                        start_bpm  = cfg_wdata[mbg_pkg::CFG_BPM_W-1:0];
                    mbg_pkg::REG_START_MEASURE:
                        start_meas = cfg_wdata[mbg_pkg::CFG_MEAS_W-1:0];
                    default:
                        ;
                endcase
            end

            // compare first so an item accepted this edge is never matched early
            if (m_tvalid && m_tready)
            begin
                got = beat_status_t'(m_tdata[STATUS_W-1:0]);
                if (got.beat)
                    beats_seen++;
                if (status_q.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              result_no));
                end
                else
                begin
                    want = status_q.pop_front();
                    check_field("beat", got.beat, want.beat);
                    check_field("accent", got.accent, want.accent);
                    check_field("running", got.running, want.running);
                    check_field("tempo", got.tempo, want.tempo);
                    check_field("measure", got.measure, want.measure);
                    check_field("interval_ms", got.interval_ms, want.interval_ms);
                    check_field("pad", int'(m_tdata[M_DATA_W-1:STATUS_W]), 0);
                end
                result_no++;
            end

            if (s_tvalid && s_tready)
                status_q.push_back(advance_metronome(
                    s_tdata[mbg_pkg::OP_W-1:0],
                    s_tdata[mbg_pkg::OP_W+mbg_pkg::DELTA_W-1:mbg_pkg::OP_W]));

            pending <= status_q.size();
        end
    end

endmodule

// File: tb/tb_metronome_beat_generator.sv
// top of the metronome beat generator testbench: clock, reset, item stimulus, settings
// writes and verdict; needs mbg_pkg, metronome_beat_generator and mbg_checker
`timescale 1ns / 100ps

module tb_metronome_beat_generator;

    localparam int M_DATA_W        = 40;
    localparam int DRAIN_CYCLES    = 30;
    localparam int RAND_PHASES     = 5;
    localparam int ITEMS_PER_PHASE = 245;
    localparam int IDLE_PCT        = 36;
    localparam int OP_W            = mbg_pkg::OP_W;
    localparam int DELTA_W         = mbg_pkg::DELTA_W;
    localparam int CFG_BPM_W       = mbg_pkg::CFG_BPM_W;
    localparam int CFG_MEAS_W      = mbg_pkg::CFG_MEAS_W;
    localparam int CFG_DATA_W      = mbg_pkg::CFG_DATA_W;

    // op codes the block does not define
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [mbg_pkg::IN_DATA_W-1:0]     s_tdata   = '0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [M_DATA_W-1:0]               m_tdata;
    logic                              cfg_we    = 1'b0;
    logic [mbg_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]             cfg_wdata = '0;

    int pending;
    int mismatches;
    int beats_seen;
    int items_sent = 0;
    bit no_gaps    = 1'b0;

    metronome_beat_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    mbg_checker #(
        .M_DATA_W (M_DATA_W)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .pending    (pending),
        .mismatches (mismatches),
        .beats_seen (beats_seen)
    );

    // 20 ns clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // receiver stalls at random except in the no-gap stretch
    always @(posedge clk)
    begin
        m_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // hard stop in case results never arrive
    initial
    begin
        #12_000_000;
        $display("timeout: %0d result items still outstanding", pending);
        $display("Some tests failed");
        $finish;
    end

    // offer one item after a random gap and hold it until accepted
    task automatic send_item(input logic [OP_W-1:0] op, input logic [DELTA_W-1:0] delta);
        if (!no_gaps)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tdata  <= {delta, op};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // hold off the sender until every expected result item is back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write both start settings, block idle
    task automatic set_start(input logic [CFG_BPM_W-1:0] bpm,
                             input logic [CFG_MEAS_W-1:0] meas);
        cfg_we    <= 1'b1;
        cfg_index <= mbg_pkg::REG_START_BPM;
        cfg_wdata <= CFG_DATA_W'(bpm);
        @(posedge clk);
        cfg_index <= mbg_pkg::REG_START_MEASURE;
        cfg_wdata <= CFG_DATA_W'(meas);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [CFG_BPM_W-1:0]  bpm;
        logic [CFG_MEAS_W-1:0] meas;
        logic [OP_W-1:0]       op;
        logic [DELTA_W-1:0]    delta;
        int                    pick;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stopped: tick, spare codes and stop leave everything alone
        send_item(mbg_pkg::OP_TICK, 5'h00);
        send_item(OP_SPARE_A, 5'h1F);
        send_item(OP_SPARE_B, 5'h0A);
        send_item(mbg_pkg::OP_STOP, 5'h15);
        // start: first tick beats accented, the next one is quiet
        send_item(mbg_pkg::OP_TOGGLE, 5'h00);
        send_item(mbg_pkg::OP_TICK, 5'h00);
        send_item(mbg_pkg::OP_TICK, 5'h00);
        // measure down to zero then back up, tempo by the largest steps
        send_item(mbg_pkg::OP_ADJ_MEASURE, 5'h10);
        send_item(mbg_pkg::OP_ADJ_MEASURE, 5'h0F);
        send_item(mbg_pkg::OP_ADJ_TEMPO, 5'h0F);
        send_item(mbg_pkg::OP_ADJ_TEMPO, 5'h10);
        send_item(mbg_pkg::OP_LOAD, 5'h15);
        // toggle off, on again, then stop
        send_item(mbg_pkg::OP_TOGGLE, 5'h00);
        send_item(mbg_pkg::OP_TOGGLE, 5'h00);
        send_item(mbg_pkg::OP_STOP, 5'h00);

        // lowest settings: tempo saturates to 1, measure 0 never accents
        wait_idle();
        set_start('0, '0);
        send_item(mbg_pkg::OP_LOAD, 5'h00);
        send_item(mbg_pkg::OP_ADJ_TEMPO, 5'h1F);
        send_item(mbg_pkg::OP_ADJ_MEASURE, 5'h1F);
        send_item(mbg_pkg::OP_TOGGLE, 5'h00);
        send_item(mbg_pkg::OP_TICK, 5'h00);

        // highest settings saturate to 500 bpm and 32 beats
        wait_idle();
        set_start('1, '1);
        send_item(mbg_pkg::OP_LOAD, 5'h00);
        send_item(mbg_pkg::OP_ADJ_TEMPO, 5'h0F);
        send_item(mbg_pkg::OP_ADJ_MEASURE, 5'h0F);
        send_item(mbg_pkg::OP_TICK, 5'h00);

        // random phases: mostly ticks while running, some control traffic
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    bpm  = 9'd500;
                    meas = 6'd3;
                end
                1:
                begin
                    bpm  = '1;
                    meas = '1;
                end
                2:
                begin
                    bpm  = 9'd480 + 9'($urandom_range(0, 31));
                    meas = 6'd1;
                end
                3:
                begin
                    bpm  = '0;
                    meas = '0;
                end
                default:
                begin
                    bpm  = 9'($urandom);
                    meas = 6'($urandom);
                end
            endcase
            wait_idle();
            no_gaps = (ph == 0);
            set_start(bpm, meas);

            // known start: stopped, settings loaded, running
            send_item(mbg_pkg::OP_STOP, 5'($urandom));
            send_item(mbg_pkg::OP_LOAD, 5'($urandom));
            send_item(mbg_pkg::OP_TOGGLE, 5'($urandom));

            repeat (ITEMS_PER_PHASE)
            begin
                pick  = $urandom_range(0, 999);
                delta = 5'($urandom);
                if (pick < 860)
                    op = mbg_pkg::OP_TICK;
                else if (pick < 885)
                    op = mbg_pkg::OP_TOGGLE;
                else if (pick < 925)
                    op = mbg_pkg::OP_ADJ_TEMPO;
                else if (pick < 965)
                    op = mbg_pkg::OP_ADJ_MEASURE;
                else if (pick < 980)
                    op = mbg_pkg::OP_LOAD;
                else if (pick < 990)
                    op = mbg_pkg::OP_STOP;
                else
                    op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
                send_item(op, delta);
            end
        end
        no_gaps = 1'b0;
        wait_idle();

        $display("summary: %0d items sent over %0d start settings, %0d beats heard",
                 items_sent, RAND_PHASES + 2, beats_seen);
        $display("summary: ticks, toggles, tempo and measure steps, loads, stops and spare codes");
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
